>>> sv/mips1_instruction_decoder_top_assert.svh
// Assertion macros for the MIPS I decoder top level.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef MIPS1_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define MIPS1_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MIPS1DEC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mips1dec: check failed");
`define MIPS1DEC_ASSERT_LAT3(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##3 (cons)) \
        else $error("mips1dec: latency check failed");
`else
`define MIPS1DEC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MIPS1DEC_ASSERT_LAT3(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/mips1dec_pkg.sv
// Shared types, mnemonic and operand-form codes, decode tables.
// No dependencies.
package mips1dec_pkg;

    typedef logic [5:0] mn_t;
    typedef logic [3:0] form_t;

    localparam mn_t MN_BAD     = 6'd0;
    localparam mn_t MN_NOP     = 6'd1;
    localparam mn_t MN_ADD     = 6'd2;
    localparam mn_t MN_ADDI    = 6'd3;
    localparam mn_t MN_ADDIU   = 6'd4;
    localparam mn_t MN_ADDU    = 6'd5;
    localparam mn_t MN_AND     = 6'd6;
    localparam mn_t MN_ANDI    = 6'd7;
    localparam mn_t MN_BEQ     = 6'd8;
    localparam mn_t MN_BGEZ    = 6'd9;
    localparam mn_t MN_BGEZAL  = 6'd10;
    localparam mn_t MN_BGTZ    = 6'd11;
    localparam mn_t MN_BLEZ    = 6'd12;
    localparam mn_t MN_BLTZ    = 6'd13;
    localparam mn_t MN_BLTZAL  = 6'd14;
    localparam mn_t MN_BNE     = 6'd15;
    localparam mn_t MN_BREAK   = 6'd16;
    localparam mn_t MN_DIV     = 6'd17;
    localparam mn_t MN_DIVU    = 6'd18;
    localparam mn_t MN_J       = 6'd19;
    localparam mn_t MN_JAL     = 6'd20;
    localparam mn_t MN_JALR    = 6'd21;
    localparam mn_t MN_JR      = 6'd22;
    localparam mn_t MN_LB      = 6'd23;
    localparam mn_t MN_LBU     = 6'd24;
    localparam mn_t MN_LH      = 6'd25;
    localparam mn_t MN_LHU     = 6'd26;
    localparam mn_t MN_LUI     = 6'd27;
    localparam mn_t MN_LW      = 6'd28;
    localparam mn_t MN_LWL     = 6'd29;
    localparam mn_t MN_LWR     = 6'd30;
    localparam mn_t MN_MFHI    = 6'd31;
    localparam mn_t MN_MFLO    = 6'd32;
    localparam mn_t MN_MTHI    = 6'd33;
    localparam mn_t MN_MTLO    = 6'd34;
    localparam mn_t MN_MULT    = 6'd35;
    localparam mn_t MN_MULTU   = 6'd36;
    localparam mn_t MN_NOR     = 6'd37;
    localparam mn_t MN_OR      = 6'd38;
    localparam mn_t MN_ORI     = 6'd39;
    localparam mn_t MN_SB      = 6'd40;
    localparam mn_t MN_SH      = 6'd41;
    localparam mn_t MN_SLL     = 6'd42;
    localparam mn_t MN_SLLV    = 6'd43;
    localparam mn_t MN_SLT     = 6'd44;
    localparam mn_t MN_SLTI    = 6'd45;
    localparam mn_t MN_SLTIU   = 6'd46;
    localparam mn_t MN_SLTU    = 6'd47;
    localparam mn_t MN_SRA     = 6'd48;
    localparam mn_t MN_SRAV    = 6'd49;
    localparam mn_t MN_SRL     = 6'd50;
    localparam mn_t MN_SRLV    = 6'd51;
    localparam mn_t MN_SUB     = 6'd52;
    localparam mn_t MN_SUBU    = 6'd53;
    localparam mn_t MN_SW      = 6'd54;
    localparam mn_t MN_SWL     = 6'd55;
    localparam mn_t MN_SWR     = 6'd56;
    localparam mn_t MN_SYSCALL = 6'd57;
    localparam mn_t MN_XOR     = 6'd58;
    localparam mn_t MN_XORI    = 6'd59;

    localparam form_t FORM_NONE       = 4'd0;
    localparam form_t FORM_RD_RS_RT   = 4'd1;
    localparam form_t FORM_RT_RS_SIMM = 4'd2;
    localparam form_t FORM_RT_RS_UIMM = 4'd3;
    localparam form_t FORM_RS_RT_BR   = 4'd4;
    localparam form_t FORM_RS_BR      = 4'd5;
    localparam form_t FORM_RS_RT      = 4'd6;
    localparam form_t FORM_JUMP       = 4'd7;
    localparam form_t FORM_RD_RS      = 4'd8;
    localparam form_t FORM_RS         = 4'd9;
    localparam form_t FORM_MEM        = 4'd10;
    localparam form_t FORM_RT_UIMM    = 4'd11;
    localparam form_t FORM_RD         = 4'd12;
    localparam form_t FORM_RD_RT_SA   = 4'd13;
    localparam form_t FORM_RD_RT_RS   = 4'd14;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic [31:0] pc;
        mn_t         mn;
    } dec_s1_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        mn_t         mn;
        form_t       form;
        logic [31:0] branch_tgt;
        logic [31:0] jump_tgt;
    } dec_s2_t;

    function automatic mn_t primary_mn(input logic [5:0] op);
        mn_t mn;
        case (op)
            6'h02:   mn = MN_J;
            6'h03:   mn = MN_JAL;
            6'h04:   mn = MN_BEQ;
            6'h05:   mn = MN_BNE;
            6'h06:   mn = MN_BLEZ;
            6'h07:   mn = MN_BGTZ;
            6'h08:   mn = MN_ADDI;
            6'h09:   mn = MN_ADDIU;
            6'h0A:   mn = MN_SLTI;
            6'h0B:   mn = MN_SLTIU;
            6'h0C:   mn = MN_ANDI;
            6'h0D:   mn = MN_ORI;
            6'h0E:   mn = MN_XORI;
            6'h0F:   mn = MN_LUI;
            6'h20:   mn = MN_LB;
            6'h21:   mn = MN_LH;
            6'h22:   mn = MN_LWL;
            6'h23:   mn = MN_LW;
            6'h24:   mn = MN_LBU;
            6'h25:   mn = MN_LHU;
            6'h26:   mn = MN_LWR;
            6'h28:   mn = MN_SB;
            6'h29:   mn = MN_SH;
            6'h2A:   mn = MN_SWL;
            6'h2B:   mn = MN_SW;
            6'h2E:   mn = MN_SWR;
            default: mn = MN_BAD;
        endcase
        return mn;
    endfunction

    function automatic mn_t special_mn(input logic [5:0] funct);
        mn_t mn;
        case (funct)
            6'h00:   mn = MN_SLL;
            6'h02:   mn = MN_SRL;
            6'h03:   mn = MN_SRA;
            6'h04:   mn = MN_SLLV;
            6'h06:   mn = MN_SRLV;
            6'h07:   mn = MN_SRAV;
            6'h08:   mn = MN_JR;
            6'h09:   mn = MN_JALR;
            6'h0C:   mn = MN_SYSCALL;
            6'h0D:   mn = MN_BREAK;
            6'h10:   mn = MN_MFHI;
            6'h11:   mn = MN_MTHI;
            6'h12:   mn = MN_MFLO;
            6'h13:   mn = MN_MTLO;
            6'h18:   mn = MN_MULT;
            6'h19:   mn = MN_MULTU;
            6'h1A:   mn = MN_DIV;
            6'h1B:   mn = MN_DIVU;
            6'h20:   mn = MN_ADD;
            6'h21:   mn = MN_ADDU;
            6'h22:   mn = MN_SUB;
            6'h23:   mn = MN_SUBU;
            6'h24:   mn = MN_AND;
            6'h25:   mn = MN_OR;
            6'h26:   mn = MN_XOR;
            6'h27:   mn = MN_NOR;
            6'h2A:   mn = MN_SLT;
            6'h2B:   mn = MN_SLTU;
            default: mn = MN_BAD;
        endcase
        return mn;
    endfunction

    function automatic mn_t regimm_mn(input logic [4:0] rt);
        mn_t mn;
        case (rt)
            5'h00:   mn = MN_BLTZ;
            5'h01:   mn = MN_BGEZ;
            5'h10:   mn = MN_BLTZAL;
            5'h11:   mn = MN_BGEZAL;
            default: mn = MN_BAD;
        endcase
        return mn;
    endfunction

    function automatic form_t form_of(input mn_t mn);
        form_t f;
        case (mn)
            MN_ADD, MN_ADDU, MN_AND, MN_NOR, MN_OR, MN_SLT, MN_SLTU,
            MN_SUB, MN_SUBU, MN_XOR:
                f = FORM_RD_RS_RT;
            MN_ADDI, MN_ADDIU, MN_SLTI, MN_SLTIU:
                f = FORM_RT_RS_SIMM;
            MN_ANDI, MN_ORI, MN_XORI:
                f = FORM_RT_RS_UIMM;
            MN_BEQ, MN_BNE:
                f = FORM_RS_RT_BR;
            MN_BGEZ, MN_BGEZAL, MN_BGTZ, MN_BLEZ, MN_BLTZ, MN_BLTZAL:
                f = FORM_RS_BR;
            MN_DIV, MN_DIVU, MN_MULT, MN_MULTU:
                f = FORM_RS_RT;
            MN_J, MN_JAL:
                f = FORM_JUMP;
            MN_JALR:
                f = FORM_RD_RS;
            MN_JR, MN_MTHI, MN_MTLO:
                f = FORM_RS;
            MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LW, MN_LWL, MN_LWR,
            MN_SB, MN_SH, MN_SW, MN_SWL, MN_SWR:
                f = FORM_MEM;
            MN_LUI:
                f = FORM_RT_UIMM;
            MN_MFHI, MN_MFLO:
                f = FORM_RD;
            MN_SLL, MN_SRA, MN_SRL:
                f = FORM_RD_RT_SA;
            MN_SLLV, MN_SRAV, MN_SRLV:
                f = FORM_RD_RT_RS;
            default:
                f = FORM_NONE;
        endcase
        return f;
    endfunction

endpackage

>>> sv/mips1dec_classify.sv
// Stage 1: opcode/function/regimm table lookup into a mnemonic id.
// Depends on mips1dec_pkg.
module mips1dec_classify
    import mips1dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] word,
    input  logic [31:0] pc,
    output dec_s1_t     s1
);

    dec_s1_t s1_reg;
    dec_s1_t s1_next;
    mn_t     mn;

    always_comb
    begin
        if (word == 32'd0)
        begin
            mn = MN_NOP;
        end
        else if (word[31:26] == OP_SPECIAL)
        begin
            mn = special_mn(word[5:0]);
        end
        else if (word[31:26] == OP_REGIMM)
        begin
            mn = regimm_mn(word[20:16]);
        end
        else
        begin
            mn = primary_mn(word[31:26]);
        end
        s1_next.valid = in_valid;
        s1_next.word  = word;
        s1_next.pc    = pc;
        s1_next.mn    = mn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

>>> sv/mips1dec_target.sv
// Stage 2: operand-form lookup, branch target add and jump target build.
// Depends on mips1dec_pkg.
module mips1dec_target
    import mips1dec_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  dec_s1_t s1,
    output dec_s2_t s2
);

    dec_s2_t     s2_reg;
    dec_s2_t     s2_next;
    logic [31:0] offset;

    always_comb
    begin
        offset             = {{14{s1.word[15]}}, s1.word[15:0], 2'b00};
        s2_next.valid      = s1.valid;
        s2_next.word       = s1.word;
        s2_next.mn         = s1.mn;
        s2_next.form       = form_of(s1.mn);
        s2_next.branch_tgt = s1.pc + 32'd4 + offset;
        s2_next.jump_tgt   = {s1.pc[31:28], s1.word[25:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

>>> sv/mips1_instruction_decoder_top.sv
// MIPS I instruction decoder, top level: stage 3 field select and output registers.
// Depends on mips1dec_pkg, mips1dec_classify, mips1dec_target and the assert header.
//
// channel  | signals                                      | transfer
// ---------+----------------------------------------------+--------------------------
// input    | start, busy, instruction_word, fetch_address | start && !busy at clk edge
// result   | done, mnemonic_id ... target_address         | done high for one cycle
//
// Three register stages: table lookup, form lookup plus target add, field select.
// A word goes through stage 1, stage 2 and the output stage, which raises done.
// One word per cycle; busy stays low, so every start is taken.
// Reset clears stages 1 and 2 and done; output fields are not reset. No stalls.
`include "mips1_instruction_decoder_top_assert.svh"

module mips1_instruction_decoder_top
    import mips1dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        instruction_word,
    input  logic [31:0]        fetch_address,
    output logic               done,
    output logic [5:0]         mnemonic_id,
    output logic [3:0]         operand_form,
    output logic [4:0]         source_reg,
    output logic [4:0]         target_reg,
    output logic [4:0]         dest_reg,
    output logic [4:0]         shift_amount,
    output logic signed [16:0] immediate_value,
    output logic [31:0]        target_address
);

    dec_s1_t s1;
    dec_s2_t s2;

    logic               done_reg;
    logic [5:0]         mn_reg;
    logic [3:0]         form_reg;
    logic [4:0]         rs_reg;
    logic [4:0]         rt_reg;
    logic [4:0]         rd_reg;
    logic [4:0]         sa_reg;
    logic signed [16:0] imm_reg;
    logic [31:0]        tgt_reg;

    logic signed [16:0] imm_next;
    logic [31:0]        tgt_next;

    logic               xfer;
    logic               bad_mn;
    logic               tgt_form;

    assign busy = 1'b0;
    assign xfer = start && !busy;

    mips1dec_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (xfer),
        .word     (instruction_word),
        .pc       (fetch_address),
        .s1       (s1)
    );

    mips1dec_target u_target (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    always_comb
    begin
        case (s2.form)
            FORM_RT_RS_SIMM, FORM_MEM:
            begin
                imm_next = {s2.word[15], s2.word[15:0]};
                tgt_next = 32'd0;
            end
            FORM_RT_RS_UIMM, FORM_RT_UIMM:
            begin
                imm_next = {1'b0, s2.word[15:0]};
                tgt_next = 32'd0;
            end
            FORM_RS_RT_BR, FORM_RS_BR:
            begin
                imm_next = {s2.word[15], s2.word[15:0]};
                tgt_next = s2.branch_tgt;
            end
            FORM_JUMP:
            begin
                imm_next = 17'sd0;
                tgt_next = s2.jump_tgt;
            end
            default:
            begin
                imm_next = 17'sd0;
                tgt_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        mn_reg   <= s2.mn;
        form_reg <= s2.form;
        rs_reg   <= s2.word[25:21];
        rt_reg   <= s2.word[20:16];
        rd_reg   <= s2.word[15:11];
        sa_reg   <= s2.word[10:6];
        imm_reg  <= imm_next;
        tgt_reg  <= tgt_next;
    end

    assign done            = done_reg;
    assign mnemonic_id     = mn_reg;
    assign operand_form    = form_reg;
    assign source_reg      = rs_reg;
    assign target_reg      = rt_reg;
    assign dest_reg        = rd_reg;
    assign shift_amount    = sa_reg;
    assign immediate_value = imm_reg;
    assign target_address  = tgt_reg;

    assign bad_mn   = (mnemonic_id == MN_BAD);
    assign tgt_form = (operand_form == FORM_RS_RT_BR) || (operand_form == FORM_RS_BR) ||
                      (operand_form == FORM_JUMP);

    `MIPS1DEC_ASSERT_LAT3(a_latency, clk, rst_n, xfer, done)
    `MIPS1DEC_ASSERT_NOW(a_no_spurious, clk, rst_n, done, $past(xfer, 3))
    `MIPS1DEC_ASSERT_NOW(a_bad_form, clk, rst_n, done && bad_mn, operand_form == FORM_NONE)
    `MIPS1DEC_ASSERT_NOW(a_tgt_zero, clk, rst_n, done && !tgt_form, target_address == 32'd0)

endmodule

>>> verif/mips1_decoder_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the MIPS I decoder: predicts every transferred word and checks each result.
// Depends on mips1dec_pkg for the mnemonic and operand-form codes.
module mips1_decoder_checker
    import mips1dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [31:0]        instruction_word,
    input  logic [31:0]        fetch_address,
    input  logic               done,
    input  logic [5:0]         mnemonic_id,
    input  logic [3:0]         operand_form,
    input  logic [4:0]         source_reg,
    input  logic [4:0]         target_reg,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         shift_amount,
    input  logic signed [16:0] immediate_value,
    input  logic [31:0]        target_address,
    output int                 mismatch_count,
    output int                 pending_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0]        word;
        logic [31:0]        pc;
        mn_t                mn;
        form_t              form;
        logic [4:0]         rs;
        logic [4:0]         rt;
        logic [4:0]         rd;
        logic [4:0]         sa;
        logic signed [16:0] imm;
        logic [31:0]        target;
    } decoded_t;

    decoded_t decode_queue[$];
    decoded_t oldest;

    function automatic mn_t opcode_lookup(input logic [5:0] op);
        case (op)
            6'h02:   return MN_J;
            6'h03:   return MN_JAL;
            6'h04:   return MN_BEQ;
            6'h05:   return MN_BNE;
            6'h06:   return MN_BLEZ;
            6'h07:   return MN_BGTZ;
            6'h08:   return MN_ADDI;
            6'h09:   return MN_ADDIU;
            6'h0A:   return MN_SLTI;
            6'h0B:   return MN_SLTIU;
            6'h0C:   return MN_ANDI;
            6'h0D:   return MN_ORI;
            6'h0E:   return MN_XORI;
            6'h0F:   return MN_LUI;
            6'h20:   return MN_LB;
            6'h21:   return MN_LH;
            6'h22:   return MN_LWL;
            6'h23:   return MN_LW;
            6'h24:   return MN_LBU;
            6'h25:   return MN_LHU;
            6'h26:   return MN_LWR;
            6'h28:   return MN_SB;
            6'h29:   return MN_SH;
            6'h2A:   return MN_SWL;
            6'h2B:   return MN_SW;
            6'h2E:   return MN_SWR;
            default: return MN_BAD;
        endcase
    endfunction

    function automatic mn_t funct_lookup(input logic [5:0] funct);
        case (funct)
            6'h00:   return MN_SLL;
            6'h02:   return MN_SRL;
            6'h03:   return MN_SRA;
            6'h04:   return MN_SLLV;
            6'h06:   return MN_SRLV;
            6'h07:   return MN_SRAV;
            6'h08:   return MN_JR;
            6'h09:   return MN_JALR;
            6'h0C:   return MN_SYSCALL;
            6'h0D:   return MN_BREAK;
            6'h10:   return MN_MFHI;
            6'h11:   return MN_MTHI;
            6'h12:   return MN_MFLO;
            6'h13:   return MN_MTLO;
            6'h18:   return MN_MULT;
            6'h19:   return MN_MULTU;
            6'h1A:   return MN_DIV;
            6'h1B:   return MN_DIVU;
            6'h20:   return MN_ADD;
            6'h21:   return MN_ADDU;
            6'h22:   return MN_SUB;
            6'h23:   return MN_SUBU;
            6'h24:   return MN_AND;
            6'h25:   return MN_OR;
            6'h26:   return MN_XOR;
            6'h27:   return MN_NOR;
            6'h2A:   return MN_SLT;
            6'h2B:   return MN_SLTU;
            default: return MN_BAD;
        endcase
    endfunction

    function automatic mn_t branch_rt_lookup(input logic [4:0] rt);
        case (rt)
            5'h00:   return MN_BLTZ;
            5'h01:   return MN_BGEZ;
            5'h10:   return MN_BLTZAL;
            5'h11:   return MN_BGEZAL;
            default: return MN_BAD;
        endcase
    endfunction

    function automatic form_t layout_class(input mn_t mn);
        case (mn)
            MN_ADD, MN_ADDU, MN_AND, MN_NOR, MN_OR, MN_SLT, MN_SLTU, MN_SUB, MN_SUBU,
            MN_XOR:
                return FORM_RD_RS_RT;
            MN_ADDI, MN_ADDIU, MN_SLTI, MN_SLTIU:
                return FORM_RT_RS_SIMM;
            MN_ANDI, MN_ORI, MN_XORI:
                return FORM_RT_RS_UIMM;
            MN_BEQ, MN_BNE:
                return FORM_RS_RT_BR;
            MN_BGEZ, MN_BGEZAL, MN_BGTZ, MN_BLEZ, MN_BLTZ, MN_BLTZAL:
                return FORM_RS_BR;
            MN_DIV, MN_DIVU, MN_MULT, MN_MULTU:
                return FORM_RS_RT;
            MN_J, MN_JAL:
                return FORM_JUMP;
            MN_JALR:
                return FORM_RD_RS;
            MN_JR, MN_MTHI, MN_MTLO:
                return FORM_RS;
            MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LW, MN_LWL, MN_LWR, MN_SB, MN_SH, MN_SW,
            MN_SWL, MN_SWR:
                return FORM_MEM;
            MN_LUI:
                return FORM_RT_UIMM;
            MN_MFHI, MN_MFLO:
                return FORM_RD;
            MN_SLL, MN_SRA, MN_SRL:
                return FORM_RD_RT_SA;
            MN_SLLV, MN_SRAV, MN_SRLV:
                return FORM_RD_RT_RS;
            default:
                return FORM_NONE;
        endcase
    endfunction

    function automatic decoded_t predict_decode(input logic [31:0] w, input logic [31:0] pc);
        decoded_t d;
        d.word   = w;
        d.pc     = pc;
        d.rs     = w[25:21];
        d.rt     = w[20:16];
        d.rd     = w[15:11];
        d.sa     = w[10:6];
        d.imm    = '0;
        d.target = '0;
        if (w == 32'h0)
            d.mn = MN_NOP;
        else if (w[31:26] == OP_SPECIAL)
            d.mn = funct_lookup(w[5:0]);
        else if (w[31:26] == OP_REGIMM)
            d.mn = branch_rt_lookup(w[20:16]);
        else
            d.mn = opcode_lookup(w[31:26]);
        d.form = layout_class(d.mn);
        case (d.form)
            FORM_RT_RS_SIMM, FORM_MEM:
                d.imm = {w[15], w[15:0]};
            FORM_RT_RS_UIMM, FORM_RT_UIMM:
                d.imm = {1'b0, w[15:0]};
            FORM_RS_RT_BR, FORM_RS_BR:
            begin
                d.imm    = {w[15], w[15:0]};
                d.target = pc + 32'd4 + {{14{w[15]}}, w[15:0], 2'b00};
            end
            FORM_JUMP:
                d.target = {pc[31:28], w[25:0], 2'b00};
            default:
                ;
        endcase
        return d;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (decode_queue.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with no word in flight: mn %0d form %0d",
                                 $realtime, mnemonic_id, operand_form);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = decode_queue.pop_front();
                    if (mnemonic_id !== oldest.mn || operand_form !== oldest.form ||
                        source_reg !== oldest.rs || target_reg !== oldest.rt ||
                        dest_reg !== oldest.rd || shift_amount !== oldest.sa ||
                        immediate_value !== oldest.imm || target_address !== oldest.target)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch word %h pc %h", $realtime,
                                     oldest.word, oldest.pc);
                            $display("  exp mn %0d form %0d rs %0d rt %0d rd %0d sa %0d imm %0d tgt %h",
                                     oldest.mn, oldest.form, oldest.rs, oldest.rt, oldest.rd,
                                     oldest.sa, oldest.imm, oldest.target);
                            $display("  got mn %0d form %0d rs %0d rt %0d rd %0d sa %0d imm %0d tgt %h",
                                     mnemonic_id, operand_form, source_reg, target_reg,
                                     dest_reg, shift_amount, immediate_value, target_address);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                decode_queue.push_back(predict_decode(instruction_word, fetch_address));
        end
        pending_count <= decode_queue.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the MIPS I decoder testbench: clock, reset, word stimulus, watchdog and verdict.
// Depends on mips1dec_pkg, mips1_instruction_decoder_top and mips1_decoder_checker.
module testbench
    import mips1dec_pkg::*;
();

    localparam int ITEM_COUNT     = 1650;
    localparam int DIRECTED_COUNT = 25;
    localparam int QUIET_TAIL     = 200;
    localparam int PAUSE_AT       = 800;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int DRAIN_CYCLES   = 8;

    localparam logic [5:0] OPC_J      = 6'h02;
    localparam logic [5:0] OPC_JAL    = 6'h03;
    localparam logic [5:0] OPC_BEQ    = 6'h04;
    localparam logic [5:0] OPC_BNE    = 6'h05;
    localparam logic [5:0] OPC_ADDI   = 6'h08;
    localparam logic [5:0] OPC_ANDI   = 6'h0C;
    localparam logic [5:0] OPC_XORI   = 6'h0E;
    localparam logic [5:0] OPC_LUI    = 6'h0F;
    localparam logic [5:0] OPC_COP0   = 6'h10;
    localparam logic [5:0] OPC_LW     = 6'h23;
    localparam logic [5:0] OPC_SWR    = 6'h2E;
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_UNUSED  = 6'h3F;
    localparam logic [4:0] RT_BGEZ    = 5'h01;
    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] RT_UNUSED  = 5'h1F;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        instruction_word;
    logic [31:0]        fetch_address;
    logic               done;
    logic [5:0]         mnemonic_id;
    logic [3:0]         operand_form;
    logic [4:0]         source_reg;
    logic [4:0]         target_reg;
    logic [4:0]         dest_reg;
    logic [4:0]         shift_amount;
    logic signed [16:0] immediate_value;
    logic [31:0]        target_address;
    int                 mismatch_count;
    int                 pending_count;
    int                 quiet_cycles;
    bit                 idle_enabled;

    mips1_instruction_decoder_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .instruction_word(instruction_word),
        .fetch_address   (fetch_address),
        .done            (done),
        .mnemonic_id     (mnemonic_id),
        .operand_form    (operand_form),
        .source_reg      (source_reg),
        .target_reg      (target_reg),
        .dest_reg        (dest_reg),
        .shift_amount    (shift_amount),
        .immediate_value (immediate_value),
        .target_address  (target_address)
    );

    mips1_decoder_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .instruction_word(instruction_word),
        .fetch_address   (fetch_address),
        .done            (done),
        .mnemonic_id     (mnemonic_id),
        .operand_form    (operand_form),
        .source_reg      (source_reg),
        .target_reg      (target_reg),
        .dest_reg        (dest_reg),
        .shift_amount    (shift_amount),
        .immediate_value (immediate_value),
        .target_address  (target_address),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] r_word(input logic [5:0] funct, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [4:0] rd,
                                           input logic [4:0] sa);
        return {OP_SPECIAL, rs, rt, rd, sa, funct};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Mostly well-formed encodings with random operand fields, some raw noise.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned pick;
        w    = $urandom();
        pick = $urandom_range(99);
        if (pick < 55)
            w[30] = 1'b0;
        else if (pick < 80)
        begin
            w[31:26] = OP_SPECIAL;
            if ($urandom_range(1) == 0)
                w[4] = 1'b0;
        end
        else if (pick < 90)
        begin
            w[31:26] = OP_REGIMM;
            w[19:17] = 3'b000;
        end
        else if (pick < 95)
            w = 32'h0;
        return w;
    endfunction

    function automatic logic [31:0] random_pc();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFC;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFC;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [31:0] w, input logic [31:0] pc);
        int unsigned gap;
        if (idle_enabled && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(11, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        instruction_word <= w;
        fetch_address    <= pc;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        instruction_word = '0;
        fetch_address    = '0;
        idle_enabled     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(r_word(FN_SLL, 5'd0, 5'd31, 5'd31, 5'd31), 32'h0000_0004);
        send_word(r_word(FN_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31), $urandom());
        send_word(i_word(OP_REGIMM, 5'd31, RT_UNUSED, 16'hFFFF), $urandom());
        send_word(i_word(OP_REGIMM, 5'd0, RT_BLTZAL, 16'h8000), 32'h0000_0000);
        send_word(i_word(OP_REGIMM, 5'd31, RT_BGEZ, 16'h7FFF), 32'hFFFF_FFFC);
        send_word(i_word(OPC_BEQ, 5'd31, 5'd31, 16'hFFFF), 32'h0000_0000);
        send_word(i_word(OPC_BNE, 5'd0, 5'd0, 16'h0000), 32'hFFFF_FFFF);
        send_word({OPC_J, 26'h3FF_FFFF}, 32'hF000_0000);
        send_word({OPC_JAL, 26'h000_0000}, 32'h8FFF_FFFF);
        send_word(i_word(OPC_LUI, 5'd0, 5'd31, 16'hFFFF), $urandom());
        send_word(i_word(OPC_ANDI, 5'd31, 5'd0, 16'h8000), $urandom());
        send_word(i_word(OPC_ADDI, 5'd1, 5'd2, 16'h8000), $urandom());
        send_word(i_word(OPC_LW, 5'd31, 5'd31, 16'h7FFF), $urandom());
        send_word(i_word(OPC_SWR, 5'd0, 5'd0, 16'hFFFF), $urandom());
        send_word(i_word(OPC_COP0, 5'd4, 5'd0, 16'h0000), $urandom());
        send_word(r_word(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), $urandom());
        send_word(r_word(FN_JALR, 5'd31, 5'd0, 5'd31, 5'd0), $urandom());
        send_word(r_word(FN_MFHI, 5'd0, 5'd0, 5'd31, 5'd0), $urandom());
        send_word(r_word(FN_SRAV, 5'd17, 5'd9, 5'd3, 5'd0), $urandom());
        send_word(r_word(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), $urandom());
        send_word({OP_SPECIAL, 20'hF_FFFF, FN_BREAK}, $urandom());
        send_word(r_word(FN_MULTU, 5'd5, 5'd6, 5'd0, 5'd0), $urandom());
        send_word(i_word(OPC_XORI, 5'd7, 5'd8, 16'h8000), $urandom());

        for (int k = 0; k < ITEM_COUNT - DIRECTED_COUNT; k++)
        begin
            // alternate stretches with and without gaps; none near the end
            idle_enabled = (k < ITEM_COUNT - DIRECTED_COUNT - QUIET_TAIL) && ((k / 150) % 3 != 2);
            if (k == PAUSE_AT)
                wait_drained();
            send_word(random_word(), random_pc());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
